@@ rtl/lsce_pkg.sv @@
// Package for the logic sample change encoder.
// Holds widths, record codes, the microcode store and the channel helper functions.
// No dependencies.
`default_nettype none

package lsce_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned CountW  = 4;
  localparam int unsigned IdW     = 7;

  localparam logic [IdW-1:0]    IdBase       = 7'd37;
  localparam logic [IdW-1:0]    IdLimit      = 7'd127;
  localparam logic [CountW-1:0] CountReset   = 4'd8;

  localparam logic KIND_TS   = 1'b0;
  localparam logic KIND_CHAN = 1'b1;

  typedef enum logic [1:0] {
    STEP_WAIT,
    STEP_STAMP,
    STEP_CHAN,
    STEP_SPARE
  } step_e;

  typedef enum logic [1:0] {
    JC_ALWAYS,
    JC_NO_WORK,
    JC_MORE
  } jump_e;

  typedef struct packed {
    logic  load;
    logic  emit_ts;
    logic  emit_ch;
    jump_e cond;
    step_e tgt_t;
    step_e tgt_f;
  } ctl_t;

  typedef struct packed {
    logic work;
    logic more;
    logic out_busy;
  } sts_t;

  function automatic ctl_t ucode(step_e s);
    ctl_t w;
    w = '{load: 1'b0, emit_ts: 1'b0, emit_ch: 1'b0, cond: JC_ALWAYS,
          tgt_t: STEP_WAIT, tgt_f: STEP_WAIT};
    unique case (s)
      STEP_WAIT: begin
        w.load  = 1'b1;
        w.cond  = JC_NO_WORK;
        w.tgt_t = STEP_WAIT;
        w.tgt_f = STEP_STAMP;
      end
      STEP_STAMP: begin
        w.emit_ts = 1'b1;
        w.cond    = JC_ALWAYS;
        w.tgt_t   = STEP_CHAN;
      end
      STEP_CHAN: begin
        w.emit_ch = 1'b1;
        w.cond    = JC_MORE;
        w.tgt_t   = STEP_CHAN;
        w.tgt_f   = STEP_WAIT;
      end
      default: begin
        w.cond  = JC_ALWAYS;
        w.tgt_t = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

  function automatic logic [SampleW-1:0] enable_mask(logic [CountW-1:0] cnt);
    logic [SampleW-1:0] m;
    for (int i = 0; i < SampleW; i++) begin
      m[i] = (cnt > CountW'(i));
    end
    return m;
  endfunction

  function automatic logic [IdxW-1:0] lowest_index(logic [SampleW-1:0] d);
    logic [IdxW-1:0] idx;
    idx = '0;
    for (int i = SampleW - 1; i >= 0; i--) begin
      if (d[i]) begin
        idx = IdxW'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [IdW-1:0] id_for(logic [IdxW-1:0] idx);
    logic [IdW:0] s;
    s = (IdW + 1)'(idx) + (IdW + 1)'(IdBase);
    if (s > (IdW + 1)'(IdLimit)) begin
      return IdLimit;
    end
    return s[IdW-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/lsce_seq.sv @@
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on lsce_pkg.
`default_nettype none

module lsce_seq import lsce_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire sts_t sts_i,
  output ctl_t      ctl_o
);

  step_e step_q, step_d;
  ctl_t  ctl;

  assign ctl   = ucode(step_q);
  assign ctl_o = ctl;

  always_comb begin
    step_d = step_q;
    if ((ctl.emit_ts || ctl.emit_ch) && sts_i.out_busy) begin
      step_d = step_q;
    end else begin
      unique case (ctl.cond)
        JC_ALWAYS:  step_d = ctl.tgt_t;
        JC_NO_WORK: step_d = !sts_i.work ? ctl.tgt_t : ctl.tgt_f;
        JC_MORE:    step_d = sts_i.more ? ctl.tgt_t : ctl.tgt_f;
        default:    step_d = STEP_WAIT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  a_no_spare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != STEP_SPARE)
    else $error("sequencer reached unused step");

  a_hold_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == STEP_STAMP && sts_i.out_busy) |=> step_q == STEP_STAMP)
    else $error("timestamp step left while output busy");

  a_stamp_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == STEP_STAMP && !sts_i.out_busy) |=> step_q == STEP_CHAN)
    else $error("timestamp not followed by channel records");

endmodule

`default_nettype wire

@@ rtl/lsce_datapath.sv @@
// Datapath: sample history, time counter, change mask and the output record register.
// Driven by the control word of lsce_seq; depends on lsce_pkg.
`default_nettype none

module lsce_datapath import lsce_pkg::*; (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire ctl_t             ctl_i,
  output sts_t                  sts_o,
  input  wire                   cfg_we_i,
  input  wire  [CountW-1:0]     cfg_channel_count_i,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire  [SampleW-1:0]    sample_bits_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output logic                  record_kind_o,
  output logic [TimeW-1:0]      time_stamp_o,
  output logic [IdxW-1:0]       channel_index_o,
  output logic                  channel_level_o,
  output logic [IdW-1:0]        id_char_o,
  output logic                  end_of_run_o
);

  logic [CountW-1:0]  count_q;
  logic [SampleW-1:0] prev_q;
  logic               first_q;
  logic [TimeW-1:0]   time_q;
  logic [TimeW-1:0]   stamp_q;
  logic [SampleW-1:0] sample_q;
  logic [SampleW-1:0] diff_q, diff_d;
  logic [SampleW-1:0] diff_nxt;
  logic [SampleW-1:0] diff_rest;
  logic [IdxW-1:0]    idx;
  logic               accept;
  logic               out_busy;
  logic               fire;
  logic               last_ch;

  logic               out_valid_q, out_valid_d;
  logic               kind_q;
  logic [TimeW-1:0]   ts_q;
  logic [IdxW-1:0]    index_q;
  logic               level_q;
  logic [IdW-1:0]     id_q;
  logic               end_q;

  assign in_stall_o = !ctl_i.load;
  assign accept     = in_valid_i && ctl_i.load;
  assign diff_nxt   = first_q ? enable_mask(count_q)
                              : (sample_bits_i ^ prev_q) & enable_mask(count_q);
  assign diff_rest  = diff_q & (diff_q - SampleW'(1));
  assign idx        = lowest_index(diff_q);
  assign last_ch    = (diff_rest == '0);
  assign out_busy   = out_valid_q && out_stall_i;
  assign fire       = (ctl_i.emit_ts || ctl_i.emit_ch) && !out_busy;

  assign sts_o = '{work: accept && (diff_nxt != '0), more: !last_ch, out_busy: out_busy};

  always_comb begin
    diff_d = diff_q;
    if (accept) begin
      diff_d = diff_nxt;
    end else if (fire && ctl_i.emit_ch) begin
      diff_d = diff_rest;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (fire) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= CountReset;
      prev_q      <= '0;
      first_q     <= 1'b1;
      time_q      <= '0;
      diff_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_channel_count_i;
      end
      if (accept) begin
        prev_q  <= sample_bits_i;
        first_q <= 1'b0;
        time_q  <= time_q + TimeW'(1);
      end
      diff_q      <= diff_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stamp_q  <= time_q;
      sample_q <= sample_bits_i;
    end
    if (fire) begin
      ts_q <= stamp_q;
      if (ctl_i.emit_ch) begin
        kind_q  <= KIND_CHAN;
        index_q <= idx;
        level_q <= sample_q[idx];
        id_q    <= id_for(idx);
        end_q   <= last_ch;
      end else begin
        kind_q  <= KIND_TS;
        index_q <= '0;
        level_q <= 1'b0;
        id_q    <= '0;
        end_q   <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign record_kind_o   = kind_q;
  assign time_stamp_o    = ts_q;
  assign channel_index_o = index_q;
  assign channel_level_o = level_q;
  assign id_char_o       = id_q;
  assign end_of_run_o    = end_q;

  a_chan_has_diff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.emit_ch |-> diff_q != '0)
    else $error("channel record requested with empty change mask");

  a_ts_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KIND_TS) |-> diff_q != '0)
    else $error("timestamp record without pending channel records");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && ctl_i.emit_ch && last_ch) |=> diff_q == '0)
    else $error("change mask not empty after last channel record");

endmodule

`default_nettype wire

@@ rtl/logic_sample_change_encoder_top.sv @@
// Top level of the logic sample change encoder.
// Instantiates lsce_seq and lsce_datapath; depends on lsce_pkg.
`default_nettype none

// A sample is taken at the wait step of the microcode sequencer. A sample with no
// change on an enabled channel leaves the sequencer at that step; a sample with k
// changed channels then emits a timestamp record and k channel records, one per
// cycle through the output register while the output is not stalled. The next
// sample is taken only once the sequencer is back at its wait step.
module logic_sample_change_encoder_top import lsce_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire  [CountW-1:0]  cfg_channel_count_i,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire  [SampleW-1:0] sample_bits_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic               record_kind_o,
  output logic [TimeW-1:0]   time_stamp_o,
  output logic [IdxW-1:0]    channel_index_o,
  output logic               channel_level_o,
  output logic [IdW-1:0]     id_char_o,
  output logic               end_of_run_o
);

  ctl_t ctl;
  sts_t sts;

  lsce_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  lsce_datapath u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .ctl_i               (ctl),
    .sts_o               (sts),
    .cfg_we_i            (cfg_we_i),
    .cfg_channel_count_i (cfg_channel_count_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .sample_bits_i       (sample_bits_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .record_kind_o       (record_kind_o),
    .time_stamp_o        (time_stamp_o),
    .channel_index_o     (channel_index_o),
    .channel_level_o     (channel_level_o),
    .id_char_o           (id_char_o),
    .end_of_run_o        (end_of_run_o)
  );

endmodule

`default_nettype wire
